[rtl/bms_pkg.sv]
// Shared types and sizing constants for the bounded multiset store.
// Used by bms_cell, bounded_multiset_store_unit and bms_checker; no dependencies.
package bms_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_COUNT  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  // Scan token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                  active;
    logic [DATA_WIDTH-1:0] value;
    logic [CNT_W-1:0]      hit_count;
    logic                  found;
    logic [IDX_W-1:0]      first;
    logic [DATA_WIDTH-1:0] last_val;
  } tok_t;

endpackage

[rtl/bms_cell.sv]
// One storage cell of the multiset chain: holds one entry and updates the passing scan token.
// Depends on bms_pkg.
module bms_cell
  import bms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_W-1:0]      idx,
  input  logic [CNT_W-1:0]      n,
  input  tok_t                  tok_in,
  output tok_t                  tok_out,
  input  logic                  wr_en,
  input  logic [DATA_WIDTH-1:0] wr_data
);

  logic [DATA_WIDTH-1:0] entry;
  logic                  valid;
  logic                  is_last;
  tok_t                  tok_next;

  assign valid   = CNT_W'(idx) < n;
  assign is_last = (CNT_W'(idx) + CNT_W'(1)) == n;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.active && valid) begin
      if (entry == tok_in.value) begin
        tok_next.hit_count = tok_in.hit_count + CNT_W'(1);
        if (!tok_in.found) begin
          tok_next.found = 1'b1;
          tok_next.first = idx;
        end
      end
      // The last valid entry is picked up for the remove swap.
      if (is_last) begin
        tok_next.last_val = entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_data;
    end
  end

endmodule

[rtl/bounded_multiset_store_unit.sv]
// Top level of the bounded multiset store: control, write-back and the cell chain.
// Depends on bms_pkg and bms_cell.
//
// Usage: an operation (opcode, value) is transferred at a rising edge where start is
// high and busy is low. Opcodes are add, remove, count matches and clear.
// A scan token then moves through a chain of CAPACITY cells, one cell per cycle,
// collecting the match count, the first matching slot and the last stored entry.
// When it leaves the chain the store is updated (add writes the next free slot,
// remove copies the last entry into the first match) and the result is registered.
// The token passes the cell registers of the chain and then the done register; done is
// then high for exactly one cycle, with ok, match_count, present and size_after valid.
// One operation is handled at a time: busy stays high for the walk through the
// chain and drops as the result appears, so the next operation may be
// transferred in the same cycle that done is high.
// The receiver cannot stall; each result must be taken in its done cycle.
// Reset empties the store (count zero) and returns the block to idle; entry words
// are not cleared, since only counted entries are ever read.
module bounded_multiset_store_unit
  import bms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] value,
  output logic        done,
  output logic        ok,
  output logic [4:0]  match_count,
  output logic        present,
  output logic [4:0]  size_after
);

  state_t                state;
  op_t                   op_q;
  logic [CNT_W-1:0]      entry_count;
  logic [CNT_W-1:0]      entry_count_next;
  tok_t                  chain [0:CAPACITY];
  tok_t                  fin;
  logic                  accept;
  logic [63:0]           value_ext;
  logic                  wr_valid;
  logic [IDX_W-1:0]      wr_idx;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  ok_next;
  logic [CNT_W-1:0]      matches_next;
  logic                  present_next;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state == S_SCAN);
  assign value_ext = 64'(value);

  always_comb begin
    chain[0]          = '0;
    chain[0].active   = accept;
    chain[0].value    = value_ext[DATA_WIDTH-1:0];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bms_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(i)),
      .n       (entry_count),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .wr_en   (wr_valid && (wr_idx == IDX_W'(i))),
      .wr_data (wr_data)
    );
  end

  assign fin = chain[CAPACITY];

  always_comb begin
    entry_count_next = entry_count;
    wr_valid         = 1'b0;
    wr_idx           = fin.first;
    wr_data          = fin.value;
    ok_next          = 1'b0;
    matches_next     = fin.hit_count;
    present_next     = fin.found;
    case (op_q)
      OP_ADD: begin
        if (entry_count < CNT_W'(CAPACITY)) begin
          wr_valid         = fin.active;
          wr_idx           = entry_count[IDX_W-1:0];
          entry_count_next = entry_count + CNT_W'(1);
          ok_next          = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (fin.found) begin
          wr_valid         = fin.active;
          wr_data          = fin.last_val;
          entry_count_next = entry_count - CNT_W'(1);
          ok_next          = 1'b1;
        end
      end
      OP_COUNT: begin
        ok_next = 1'b1;
      end
      OP_CLEAR: begin
        entry_count_next = '0;
        matches_next     = '0;
        present_next     = 1'b0;
        ok_next          = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= fin.active;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (fin.active) begin
            state       <= S_IDLE;
            entry_count <= entry_count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op_t'(opcode);
    end
    if (fin.active) begin
      ok          <= ok_next;
      match_count <= 5'(matches_next);
      present     <= present_next;
      size_after  <= 5'(entry_count_next);
    end
  end

endmodule

[rtl/bms_checker.sv]
// Port-level checks for bounded_multiset_store_unit, attached by a bind statement.
// Depends on bms_pkg and the top level's ports.
module bms_checker
  import bms_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [4:0] match_count,
  input logic       present,
  input logic [4:0] size_after
);

  // A result always ends the scan, so the block is free while it is shown.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("transfer did not start a scan");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(size_after) <= CAPACITY))
    else $error("size beyond capacity");

  // Presence and a nonzero match count are the same fact.
  a_present_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (present == (match_count != 5'd0)))
    else $error("present disagrees with match count");

endmodule

bind bounded_multiset_store_unit bms_checker u_bms_checker (.*);

[verif/bounded_multiset_store_unit_tb.sv]
// Self-checking testbench for bounded_multiset_store_unit: directed and random operations
// checked against a behavioral bag model. Depends on bms_pkg and the unit's RTL only.
module bounded_multiset_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bms_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct {
    op_t        op;
    logic       ok;
    logic [4:0] hit_count;
    logic       present;
    logic [4:0] size;
  } bag_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [31:0] value;
  logic        done;
  logic        ok;
  logic [4:0]  match_count;
  logic        present;
  logic [4:0]  size_after;

  // Behavioral copy of the store.
  logic [DATA_WIDTH-1:0] bag_words [CAPACITY];
  int unsigned           bag_size;

  bag_result_t  pending_results [$];
  logic [31:0]  value_pool [4];
  int unsigned  max_gap;
  int unsigned  error_count;
  int unsigned  results_checked;
  int unsigned  idle_cycles;
  int unsigned  ops_sent [4];
  int unsigned  full_rejects;
  int unsigned  remove_hits;

  bounded_multiset_store_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .value       (value),
    .done        (done),
    .ok          (ok),
    .match_count (match_count),
    .present     (present),
    .size_after  (size_after)
  );

  always #10 clk = ~clk;

  // Applies one operation to the bag model and returns the result it should produce.
  function automatic bag_result_t apply_op_to_model(op_t op, logic [31:0] data);
    bag_result_t           r;
    logic [DATA_WIDTH-1:0] key;
    int unsigned           hits;
    int unsigned           first_hit;
    bit                    hit;
    key = data[DATA_WIDTH-1:0];
    hits = 0;
    first_hit = 0;
    hit = 1'b0;
    for (int i = 0; i < bag_size; i++) begin
      if (bag_words[i] == key) begin
        if (!hit) first_hit = i;
        hit = 1'b1;
        hits++;
      end
    end
    r.op = op;
    r.ok = 1'b1;
    case (op)
      OP_ADD: begin
        if (bag_size < CAPACITY) begin
          bag_words[bag_size] = key;
          bag_size++;
        end else begin
          r.ok = 1'b0;
          full_rejects++;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          bag_size--;
          bag_words[first_hit] = bag_words[bag_size];
          remove_hits++;
        end else begin
          r.ok = 1'b0;
        end
      end
      OP_COUNT: ;
      default: begin
        bag_size = 0;
        hits = 0;
        hit = 1'b0;
      end
    endcase
    r.hit_count = hits[4:0];
    r.present = hit;
    r.size = bag_size[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Sends one operation after a random gap; returns at the edge that takes the transfer.
  task automatic send_op(op_t op, logic [31:0] data);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      opcode <= 2'($urandom_range(0, 3));
      value <= $urandom();
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    value <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results = {pending_results, apply_op_to_model(op, data)};
    ops_sent[op]++;
  endtask

  // Results are checked at the edge that ends the done cycle.
  always @(posedge clk) begin : result_check
    bag_result_t want;
    if (!rst && done === 1'b1) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no operation pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok)
          report_mismatch({want.op.name(), " ok"}, ok, want.ok);
        if (match_count !== want.hit_count)
          report_mismatch({want.op.name(), " match_count"}, match_count, want.hit_count);
        if (present !== want.present)
          report_mismatch({want.op.name(), " present"}, present, want.present);
        if (size_after !== want.size)
          report_mismatch({want.op.name(), " size_after"}, size_after, want.size);
      end
    end
  end

  always @(posedge clk) begin
    if ((!rst && start && !busy) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_store();
    max_gap = 17;
    send_op(OP_REMOVE, 32'h0000_0007);
    send_op(OP_COUNT, 32'h0000_0000);
  endtask

  // Extreme values, a remove that moves the last entry into the hole, and clear.
  task automatic test_extremes_and_swap();
    send_op(OP_ADD, 32'h0000_0000);
    send_op(OP_ADD, 32'hFFFF_FFFF);
    send_op(OP_ADD, 32'h0000_0000);
    send_op(OP_ADD, 32'h1234_5678);
    send_op(OP_REMOVE, 32'h0000_0000);
    send_op(OP_COUNT, 32'h0000_0000);
    send_op(OP_COUNT, 32'hFFFF_FFFF);
    send_op(OP_REMOVE, 32'h0000_0005);
    send_op(OP_CLEAR, 32'hFFFF_FFFF);
    send_op(OP_COUNT, 32'h1234_5678);
  endtask

  // Every slot holds the same word, so the match count reaches its top value.
  task automatic test_full_store();
    max_gap = 0;
    for (int i = 0; i < CAPACITY; i++) send_op(OP_ADD, 32'hA5A5_5A5A);
    max_gap = 17;
    send_op(OP_ADD, 32'h5A5A_A5A5);
    send_op(OP_COUNT, 32'hA5A5_5A5A);
    send_op(OP_REMOVE, 32'hA5A5_5A5A);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4 && bag_size > 0) return 32'(bag_words[$urandom_range(0, bag_size - 1)]);
    if (r < 7) return value_pool[$urandom_range(0, 3)];
    return $urandom();
  endfunction

  // Random operations with a weighted mix; a small value pool keeps matches frequent.
  task automatic test_random_traffic(int unsigned count, int unsigned gap_limit,
                                     int unsigned add_pct, int unsigned remove_pct);
    int unsigned r;
    op_t         op;
    max_gap = gap_limit;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = $urandom();
    value_pool[3] = $urandom();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) value_pool[$urandom_range(2, 3)] = $urandom();
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_CLEAR;
      else if (r < 2 + add_pct) op = OP_ADD;
      else if (r < 2 + add_pct + remove_pct) op = OP_REMOVE;
      else op = OP_COUNT;
      send_op(op, pick_value());
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    opcode <= OP_ADD;
    value <= '0;
    bag_size = 0;
    error_count = 0;
    results_checked = 0;
    idle_cycles = 0;
    full_rejects = 0;
    remove_hits = 0;
    max_gap = 17;
    foreach (ops_sent[i]) ops_sent[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_extremes_and_swap();
    test_full_store();
    test_random_traffic(200, 17, 60, 15);
    test_random_traffic(150, 0, 25, 50);
    test_random_traffic(150, 17, 40, 35);
    test_random_traffic(150, 5, 55, 25);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);

    $display("Transfers: %0d add, %0d remove, %0d count, %0d clear; %0d results checked",
             ops_sent[OP_ADD], ops_sent[OP_REMOVE], ops_sent[OP_COUNT], ops_sent[OP_CLEAR],
             results_checked);
    $display("Adds refused on a full store: %0d, removes that found an entry: %0d",
             full_rejects, remove_hits);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
